FILE: hdl/qyhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qyhc_pkg;

  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int QUAT_W      = 16;
  localparam int YAW_W       = 13;
  localparam int ERR_W       = 14;
  localparam int EMAG_W      = 13;
  localparam int ACTION_W    = 2;
  localparam int SPEED_W     = 8;
  localparam int TIME_W      = 16;
  localparam int GAIN_W      = 4;
  localparam int DEAD_W      = 12;
  localparam int SPD_SHIFT   = 4;
  localparam int SPD_RAW_W   = EMAG_W + GAIN_W - SPD_SHIFT;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam int ANG_W     = 32;
  localparam int ANG_FRAC  = 16;
  localparam int TABLE_LEN = 24;
  localparam int YAW_MAX   = 2880;

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(YAW_MAX) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_ROUND = ANG_W'(1) <<< (ANG_FRAC - 1);

  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(3);
  localparam logic [SPEED_W-1:0] LIMIT_RST = SPEED_W'(100);
  localparam logic [DEAD_W-1:0] DEAD_RST  = DEAD_W'(48);
  localparam logic [TIME_W-1:0] TIME_RST  = TIME_W'(200);

  typedef enum logic [ACTION_W-1:0] {
    ACT_HOLD  = 2'd0,
    ACT_RIGHT = 2'd1,
    ACT_LEFT  = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN  = 2'd0,
    CFG_LIMIT = 2'd1,
    CFG_DEAD  = 2'd2,
    CFG_TIME  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [YAW_W-1:0] target;
  } side_t;

  // Arctangent of 2^-idx in units of 2^-20 degree.
  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      0:       v = 47185920;
      1:       v = 27855475;
      2:       v = 14718068;
      3:       v = 7471121;
      4:       v = 3750058;
      5:       v = 1876857;
      6:       v = 938658;
      7:       v = 469357;
      8:       v = 234682;
      9:       v = 117342;
      10:      v = 58671;
      11:      v = 29335;
      12:      v = 14668;
      13:      v = 7334;
      14:      v = 3667;
      15:      v = 1833;
      16:      v = 917;
      17:      v = 458;
      18:      v = 229;
      19:      v = 115;
      20:      v = 57;
      21:      v = 29;
      22:      v = 14;
      23:      v = 7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/qyhc_sensor_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qyhc_sensor_if;
  logic                               valid;
  logic                               ready;
  logic                               sample_ready;
  logic signed [qyhc_pkg::QUAT_W-1:0] quat_w;
  logic signed [qyhc_pkg::QUAT_W-1:0] quat_x;
  logic signed [qyhc_pkg::QUAT_W-1:0] quat_y;
  logic signed [qyhc_pkg::QUAT_W-1:0] quat_z;
  logic signed [qyhc_pkg::YAW_W-1:0]  target_yaw;

  modport source (
    output valid, sample_ready, quat_w, quat_x, quat_y, quat_z, target_yaw,
    input  ready
  );

  modport sink (
    input  valid, sample_ready, quat_w, quat_x, quat_y, quat_z, target_yaw,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/qyhc_command_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qyhc_command_if;
  logic                               valid;
  logic                               ready;
  logic signed [qyhc_pkg::YAW_W-1:0]  yaw_angle;
  logic signed [qyhc_pkg::ERR_W-1:0]  heading_error;
  logic [qyhc_pkg::ACTION_W-1:0]      action;
  logic [qyhc_pkg::SPEED_W-1:0]       drive_speed;
  logic [qyhc_pkg::TIME_W-1:0]        drive_time;

  modport source (
    output valid, yaw_angle, heading_error, action, drive_speed, drive_time,
    input  ready
  );

  modport sink (
    input  valid, yaw_angle, heading_error, action, drive_speed, drive_time,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/qyhc_yaw.sv
`timescale 1ns / 1ps
`default_nettype none

module qyhc_yaw #(
  parameter int CORDIC_STEPS   = qyhc_pkg::CORDIC_STEPS_DEF,
  parameter int QUAT_FRAC_BITS = qyhc_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 sample_ready,
  input  wire logic signed [qyhc_pkg::QUAT_W-1:0]   quat_w,
  input  wire logic signed [qyhc_pkg::QUAT_W-1:0]   quat_x,
  input  wire logic signed [qyhc_pkg::QUAT_W-1:0]   quat_y,
  input  wire logic signed [qyhc_pkg::QUAT_W-1:0]   quat_z,
  input  wire qyhc_pkg::side_t                      side_in,
  output logic signed [qyhc_pkg::YAW_W-1:0]         yaw_angle,
  output qyhc_pkg::side_t                           side_out
);

  localparam int PROD_W     = 2 * qyhc_pkg::QUAT_W;
  localparam int SC_W       = (2 * QUAT_FRAC_BITS + 2 > PROD_W + 2) ?
                              2 * QUAT_FRAC_BITS + 2 : PROD_W + 2;
  localparam int LIM_W      = 41;
  localparam int NORM_STEPS = (SC_W > LIM_W) ? SC_W - (LIM_W - 1) : 0;
  localparam int LW         = (SC_W > LIM_W) ? LIM_W : SC_W;
  localparam int CW         = LW + 2;
  localparam int AW         = qyhc_pkg::ANG_W;

  localparam logic signed [SC_W-1:0] ONE =
    {{(SC_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);
  localparam logic signed [AW-1:0] YAW_HI = AW'(qyhc_pkg::YAW_MAX);
  localparam logic signed [AW-1:0] YAW_LO = -AW'(qyhc_pkg::YAW_MAX);

  typedef struct packed {
    qyhc_pkg::side_t side;
    logic            sample;
    logic            zero;
  } ctl_t;

  // Products.
  logic signed [PROD_W-1:0] p_wz, p_xy, p_yy, p_zz;
  ctl_t                     ctl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (en) begin
      ctl1.side   <= side_in;
      ctl1.sample <= sample_ready;
      ctl1.zero   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // Sine and cosine terms.
  logic signed [SC_W-1:0] s_sum, q_sum, s_comb, c_comb;
  logic signed [SC_W-1:0] nrm_s [NORM_STEPS+1];
  logic signed [SC_W-1:0] nrm_c [NORM_STEPS+1];
  ctl_t                   nrm_ctl [NORM_STEPS+1];

  assign s_sum  = SC_W'(p_wz) + SC_W'(p_xy);
  assign q_sum  = SC_W'(p_yy) + SC_W'(p_zz);
  assign s_comb = s_sum <<< 1;
  assign c_comb = ONE - (q_sum <<< 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_ctl[0] <= '0;
    end else if (en) begin
      nrm_ctl[0].side   <= ctl1.side;
      nrm_ctl[0].sample <= ctl1.sample;
      nrm_ctl[0].zero   <= (s_comb == '0) && (c_comb == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_s[0] <= s_comb;
      nrm_c[0] <= c_comb;
    end
  end

  // Large vectors are halved one bit a stage until both parts fit.
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam logic signed [SC_W-1:0] LIM = {{(SC_W-1){1'b0}}, 1'b1} << (LIM_W - 1);
    logic big;

    assign big = (nrm_s[k] >= LIM) || (nrm_s[k] <= -LIM) ||
                 (nrm_c[k] >= LIM) || (nrm_c[k] <= -LIM);

    always_ff @(posedge clk) begin
      if (rst) begin
        nrm_ctl[k+1] <= '0;
      end else if (en) begin
        nrm_ctl[k+1] <= nrm_ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm_s[k+1] <= big ? (nrm_s[k] >>> 1) : nrm_s[k];
        nrm_c[k+1] <= big ? (nrm_c[k] >>> 1) : nrm_c[k];
      end
    end
  end

  // Left half plane is folded over by a half turn.
  logic signed [CW-1:0] cd_s [CORDIC_STEPS+1];
  logic signed [CW-1:0] cd_c [CORDIC_STEPS+1];
  logic signed [AW-1:0] cd_a [CORDIC_STEPS+1];
  ctl_t                 cd_ctl [CORDIC_STEPS+1];
  logic signed [CW-1:0] f_s, f_c;

  assign f_s = CW'($signed(nrm_s[NORM_STEPS][LW-1:0]));
  assign f_c = CW'($signed(nrm_c[NORM_STEPS][LW-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_ctl[0] <= '0;
    end else if (en) begin
      cd_ctl[0] <= nrm_ctl[NORM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_c < 0) begin
        cd_a[0] <= (f_s >= 0) ? qyhc_pkg::HALF_TURN : -qyhc_pkg::HALF_TURN;
        cd_c[0] <= -f_c;
        cd_s[0] <= -f_s;
      end else begin
        cd_a[0] <= '0;
        cd_c[0] <= f_c;
        cd_s[0] <= f_s;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATAN = qyhc_pkg::atan_entry(i);
    logic signed [CW-1:0] sh_s, sh_c;

    assign sh_s = cd_s[i] >>> i;
    assign sh_c = cd_c[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cd_ctl[i+1] <= '0;
      end else if (en) begin
        cd_ctl[i+1] <= cd_ctl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cd_s[i] > 0) begin
          cd_c[i+1] <= cd_c[i] + sh_s;
          cd_s[i+1] <= cd_s[i] - sh_c;
          cd_a[i+1] <= cd_a[i] + ATAN;
        end else begin
          cd_c[i+1] <= cd_c[i] - sh_s;
          cd_s[i+1] <= cd_s[i] + sh_c;
          cd_a[i+1] <= cd_a[i] - ATAN;
        end
      end
    end
  end

  // Rounding to 1/16 degree and clamping.
  logic signed [AW-1:0] rnd, deg;
  logic signed [qyhc_pkg::YAW_W-1:0] yaw_comb;

  assign rnd = (cd_a[CORDIC_STEPS] + qyhc_pkg::ANG_ROUND) >>> qyhc_pkg::ANG_FRAC;

  always_comb begin
    priority if (rnd > YAW_HI) begin
      deg = YAW_HI;
    end else if (rnd < YAW_LO) begin
      deg = YAW_LO;
    end else begin
      deg = rnd;
    end
    if (!cd_ctl[CORDIC_STEPS].sample || cd_ctl[CORDIC_STEPS].zero) begin
      yaw_comb = '0;
    end else begin
      yaw_comb = deg[qyhc_pkg::YAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= cd_ctl[CORDIC_STEPS].side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_angle <= yaw_comb;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/quaternion_yaw_heading_correction.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role   Contents
// sensor    sink   sample_ready, quat_w/x/y/z (Q1.14), target_yaw
// command   source yaw_angle, heading_error, action, drive_speed, drive_time
// cfg       write  gain, speed_limit, deadband, turn_time_ms
//
// One request enters every cycle while the command side does not stall; the result passes
// through the product, sum, normalizing, fold, CORDIC, yaw output, error and command
// registers, with one CORDIC step per stage.
// Reset is synchronous, clears all valid bits and loads the config registers with their reset values.
// A stall on the command side freezes the whole pipeline and holds sensor ready low.

module quaternion_yaw_heading_correction #(
  parameter int CORDIC_STEPS   = qyhc_pkg::CORDIC_STEPS_DEF,
  parameter int QUAT_FRAC_BITS = qyhc_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [qyhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [qyhc_pkg::CFG_DATA_W-1:0]     cfg_data,
  qyhc_sensor_if.sink                              sensor,
  qyhc_command_if.source                           command
);

  logic                             en;
  logic [qyhc_pkg::GAIN_W-1:0]      gain;
  logic [qyhc_pkg::SPEED_W-1:0]     speed_limit;
  logic [qyhc_pkg::DEAD_W-1:0]      deadband;
  logic [qyhc_pkg::TIME_W-1:0]      turn_time_ms;

  assign en           = !command.valid || command.ready;
  assign sensor.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= qyhc_pkg::GAIN_RST;
      speed_limit  <= qyhc_pkg::LIMIT_RST;
      deadband     <= qyhc_pkg::DEAD_RST;
      turn_time_ms <= qyhc_pkg::TIME_RST;
    end else if (cfg_we) begin
      unique case (qyhc_pkg::cfg_reg_t'(cfg_index))
        qyhc_pkg::CFG_GAIN:  gain         <= cfg_data[qyhc_pkg::GAIN_W-1:0];
        qyhc_pkg::CFG_LIMIT: speed_limit  <= cfg_data[qyhc_pkg::SPEED_W-1:0];
        qyhc_pkg::CFG_DEAD:  deadband     <= cfg_data[qyhc_pkg::DEAD_W-1:0];
        qyhc_pkg::CFG_TIME:  turn_time_ms <= cfg_data[qyhc_pkg::TIME_W-1:0];
      endcase
    end
  end

  qyhc_pkg::side_t                    side_in, side_yaw;
  logic signed [qyhc_pkg::YAW_W-1:0]  yaw;

  assign side_in.valid  = sensor.valid;
  assign side_in.target = sensor.target_yaw;

  qyhc_yaw #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_yaw (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .sample_ready (sensor.sample_ready),
    .quat_w       (sensor.quat_w),
    .quat_x       (sensor.quat_x),
    .quat_y       (sensor.quat_y),
    .quat_z       (sensor.quat_z),
    .side_in      (side_in),
    .yaw_angle    (yaw),
    .side_out     (side_yaw)
  );

  // Error and raw proportional speed.
  localparam int MUL_W = qyhc_pkg::EMAG_W + qyhc_pkg::GAIN_W;

  logic signed [qyhc_pkg::ERR_W-1:0]   err_comb, abs_comb;
  logic [MUL_W-1:0]                    mul_comb;
  logic                                e_valid;
  logic signed [qyhc_pkg::YAW_W-1:0]   e_yaw;
  logic signed [qyhc_pkg::ERR_W-1:0]   e_err;
  logic [qyhc_pkg::EMAG_W-1:0]         e_mag;
  logic [qyhc_pkg::SPD_RAW_W-1:0]      e_spd;

  assign err_comb = qyhc_pkg::ERR_W'(side_yaw.target) - qyhc_pkg::ERR_W'(yaw);
  assign abs_comb = (err_comb < 0) ? -err_comb : err_comb;
  assign mul_comb = {{qyhc_pkg::GAIN_W{1'b0}}, abs_comb[qyhc_pkg::EMAG_W-1:0]} *
                    {{qyhc_pkg::EMAG_W{1'b0}}, gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= side_yaw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_yaw <= yaw;
      e_err <= err_comb;
      e_mag <= abs_comb[qyhc_pkg::EMAG_W-1:0];
      e_spd <= mul_comb[MUL_W-1:qyhc_pkg::SPD_SHIFT];
    end
  end

  // Clamp, deadband and turn direction.
  logic [qyhc_pkg::SPEED_W-1:0] spd_clamp;
  logic                         turn;
  logic                         right;

  assign spd_clamp = (e_spd > qyhc_pkg::SPD_RAW_W'(speed_limit)) ?
                     speed_limit : e_spd[qyhc_pkg::SPEED_W-1:0];
  assign turn      = e_mag > qyhc_pkg::EMAG_W'(deadband);
  assign right     = (e_err > 0) && (spd_clamp != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (en) begin
      command.valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      command.yaw_angle     <= e_yaw;
      command.heading_error <= e_err;
      if (turn) begin
        command.action      <= right ? qyhc_pkg::ACT_RIGHT : qyhc_pkg::ACT_LEFT;
        command.drive_speed <= spd_clamp;
        command.drive_time  <= turn_time_ms;
      end else begin
        command.action      <= qyhc_pkg::ACT_HOLD;
        command.drive_speed <= '0;
        command.drive_time  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PIPE_LATENCY   = 22;
  localparam int YAW_STEPS      = 16;
  localparam int FRAC_BITS      = 14;
  localparam int DEG_FRAC       = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 120;
  localparam int HOLD_AT_RESULT = 450;
  localparam longint HALF_TURN_FIX = longint'(qyhc_pkg::YAW_MAX) <<< DEG_FRAC;

  typedef struct packed {
    logic                               sample_ready;
    logic signed [qyhc_pkg::QUAT_W-1:0] qw;
    logic signed [qyhc_pkg::QUAT_W-1:0] qx;
    logic signed [qyhc_pkg::QUAT_W-1:0] qy;
    logic signed [qyhc_pkg::QUAT_W-1:0] qz;
    logic signed [qyhc_pkg::YAW_W-1:0]  target;
  } sensor_req_t;

  typedef struct packed {
    logic signed [qyhc_pkg::YAW_W-1:0] yaw_angle;
    logic signed [qyhc_pkg::ERR_W-1:0] heading_error;
    qyhc_pkg::action_t                 action;
    logic [qyhc_pkg::SPEED_W-1:0]      drive_speed;
    logic [qyhc_pkg::TIME_W-1:0]       drive_time;
  } heading_cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  qyhc_pkg::cfg_reg_t cfg_index;
  logic [qyhc_pkg::CFG_DATA_W-1:0] cfg_data;

  qyhc_sensor_if  sensor_ch ();
  qyhc_command_if command_ch ();

  quaternion_yaw_heading_correction DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sensor    (sensor_ch),
    .command   (command_ch)
  );

  // Arctangent of 2^-i in units of 2^-20 degree.
  longint arctan_tab [0:23] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic [qyhc_pkg::GAIN_W-1:0]  gain_r  = qyhc_pkg::GAIN_W'(3);
  logic [qyhc_pkg::SPEED_W-1:0] limit_r = qyhc_pkg::SPEED_W'(100);
  logic [qyhc_pkg::DEAD_W-1:0]  dead_r  = qyhc_pkg::DEAD_W'(48);
  logic [qyhc_pkg::TIME_W-1:0]  time_r  = qyhc_pkg::TIME_W'(200);

  sensor_req_t  pending_reqs [$];
  heading_cmd_t expected_cmds [$];
  sensor_req_t  offered;
  logic         calm = 1'b0;
  int           mismatches = 0;
  int           results_seen;
  int           hold_left;
  logic         hold_done;
  int           quiet_cycles;

  function automatic logic signed [qyhc_pkg::YAW_W-1:0] yaw_from_quat(
    input logic signed [qyhc_pkg::QUAT_W-1:0] qw, qx, qy, qz);
    longint s, c, ang, ns, nc, r;
    s = 2 * (longint'(qw) * qz + longint'(qx) * qy);
    c = (longint'(1) <<< (2 * FRAC_BITS)) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
    if (s == 0 && c == 0) begin
      return '0;
    end
    while ((s < 0 ? -s : s) >= (longint'(1) <<< 40) ||
           (c < 0 ? -c : c) >= (longint'(1) <<< 40)) begin
      s = s >>> 1;
      c = c >>> 1;
    end
    ang = 0;
    if (c < 0) begin
      ang = (s >= 0) ? HALF_TURN_FIX : -HALF_TURN_FIX;
      c = -c;
      s = -s;
    end
    for (int i = 0; i < YAW_STEPS && i < 24; i++) begin
      if (s > 0) begin
        nc = c + (s >>> i);
        ns = s - (c >>> i);
        ang += arctan_tab[i];
      end else begin
        nc = c - (s >>> i);
        ns = s + (c >>> i);
        ang -= arctan_tab[i];
      end
      c = nc;
      s = ns;
    end
    r = (ang + (longint'(1) <<< (DEG_FRAC - 1))) >>> DEG_FRAC;
    if (r > qyhc_pkg::YAW_MAX) r = qyhc_pkg::YAW_MAX;
    if (r < -qyhc_pkg::YAW_MAX) r = -qyhc_pkg::YAW_MAX;
    return r[qyhc_pkg::YAW_W-1:0];
  endfunction

  function automatic heading_cmd_t plan_correction(input sensor_req_t rq);
    heading_cmd_t o;
    longint yaw, err, emag, spd;
    yaw = 0;
    if (rq.sample_ready) begin
      yaw = longint'(yaw_from_quat(rq.qw, rq.qx, rq.qy, rq.qz));
    end
    err = longint'(rq.target) - yaw;
    emag = (err < 0) ? -err : err;
    spd = (emag * longint'(gain_r)) >>> qyhc_pkg::SPD_SHIFT;
    if (spd > longint'(limit_r)) spd = longint'(limit_r);
    o.yaw_angle = yaw[qyhc_pkg::YAW_W-1:0];
    o.heading_error = err[qyhc_pkg::ERR_W-1:0];
    o.action = qyhc_pkg::ACT_HOLD;
    o.drive_speed = '0;
    o.drive_time = '0;
    if (emag > longint'(dead_r)) begin
      o.action = (err > 0 && spd > 0) ? qyhc_pkg::ACT_RIGHT : qyhc_pkg::ACT_LEFT;
      o.drive_speed = spd[qyhc_pkg::SPEED_W-1:0];
      o.drive_time = time_r;
    end
    return o;
  endfunction

  function automatic sensor_req_t random_request();
    sensor_req_t rq;
    int kind, aim;
    real a, b, c, d, norm;
    longint yaw, off;
    kind = $urandom_range(0, 99);
    rq.sample_ready = (kind >= 8);
    if (kind < 20) begin
      rq.qw = 16'($urandom);
      rq.qx = 16'($urandom);
      rq.qy = 16'($urandom);
      rq.qz = 16'($urandom);
    end else if (kind < 35) begin
      rq.qw = 16'(int'($urandom_range(0, 32768)) - 16384);
      rq.qx = 16'(int'($urandom_range(0, 32768)) - 16384);
      rq.qy = 16'(int'($urandom_range(0, 32768)) - 16384);
      rq.qz = 16'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      a = real'(int'($urandom_range(0, 32768)) - 16384);
      b = real'(int'($urandom_range(0, 32768)) - 16384);
      c = real'(int'($urandom_range(0, 32768)) - 16384);
      d = real'(int'($urandom_range(0, 32768)) - 16384);
      norm = $sqrt(a * a + b * b + c * c + d * d);
      if (norm < 1.0) begin
        a = 1.0;
        norm = 1.0;
      end
      rq.qw = 16'($rtoi(a * 16384.0 / norm));
      rq.qx = 16'($rtoi(b * 16384.0 / norm));
      rq.qy = 16'($rtoi(c * 16384.0 / norm));
      rq.qz = 16'($rtoi(d * 16384.0 / norm));
    end
    aim = $urandom_range(0, 99);
    if (aim < 10) begin
      rq.target = qyhc_pkg::YAW_W'($urandom);
    end else if (aim < 45) begin
      yaw = 0;
      if (rq.sample_ready) begin
        yaw = longint'(yaw_from_quat(rq.qw, rq.qx, rq.qy, rq.qz));
      end
      off = longint'(dead_r) + longint'(int'($urandom_range(0, 4))) - 2;
      if ($urandom_range(0, 1) == 1) off = -off;
      rq.target = qyhc_pkg::YAW_W'(yaw + off);
    end else begin
      rq.target = qyhc_pkg::YAW_W'(int'($urandom_range(0, 2 * qyhc_pkg::YAW_MAX)) -
                                   qyhc_pkg::YAW_MAX);
    end
    return rq;
  endfunction

  task automatic add_request(input logic sr, input int w, x, y, z, t);
    sensor_req_t rq;
    rq.sample_ready = sr;
    rq.qw = qyhc_pkg::QUAT_W'(w);
    rq.qx = qyhc_pkg::QUAT_W'(x);
    rq.qy = qyhc_pkg::QUAT_W'(y);
    rq.qz = qyhc_pkg::QUAT_W'(z);
    rq.target = qyhc_pkg::YAW_W'(t);
    pending_reqs.push_back(rq);
  endtask

  task automatic write_reg(input qyhc_pkg::cfg_reg_t idx,
                           input logic [qyhc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      qyhc_pkg::CFG_GAIN:  gain_r = val[qyhc_pkg::GAIN_W-1:0];
      qyhc_pkg::CFG_LIMIT: limit_r = val[qyhc_pkg::SPEED_W-1:0];
      qyhc_pkg::CFG_DEAD:  dead_r = val[qyhc_pkg::DEAD_W-1:0];
      qyhc_pkg::CFG_TIME:  time_r = val[qyhc_pkg::TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [qyhc_pkg::CFG_DATA_W-1:0] g, l, d, t);
    write_reg(qyhc_pkg::CFG_GAIN, g);
    write_reg(qyhc_pkg::CFG_LIMIT, l);
    write_reg(qyhc_pkg::CFG_DEAD, d);
    write_reg(qyhc_pkg::CFG_TIME, t);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_random(input int count);
    for (int n = 0; n < count; n++) begin
      pending_reqs.push_back(random_request());
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (!(pending_reqs.size() == 0 && !sensor_ch.valid && expected_cmds.size() == 0)) begin
      @(negedge clk);
    end
  endtask

  task automatic report_field(input string name, input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      sensor_ch.valid <= 1'b0;
    end else begin
      if (sensor_ch.valid && sensor_ch.ready) begin
        expected_cmds.push_back(plan_correction(offered));
      end
      if (!sensor_ch.valid || sensor_ch.ready) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          offered = pending_reqs.pop_front();
          sensor_ch.valid <= 1'b1;
          sensor_ch.sample_ready <= offered.sample_ready;
          sensor_ch.quat_w <= offered.qw;
          sensor_ch.quat_x <= offered.qx;
          sensor_ch.quat_y <= offered.qy;
          sensor_ch.quat_z <= offered.qz;
          sensor_ch.target_yaw <= offered.target;
        end else begin
          sensor_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    heading_cmd_t got, want;
    if (rst) begin
      command_ch.ready <= 1'b0;
      results_seen <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (command_ch.valid && command_ch.ready) begin
        results_seen <= results_seen + 1;
        got.yaw_angle = command_ch.yaw_angle;
        got.heading_error = command_ch.heading_error;
        got.action = qyhc_pkg::action_t'(command_ch.action);
        got.drive_speed = command_ch.drive_speed;
        got.drive_time = command_ch.drive_time;
        if (expected_cmds.size() == 0) begin
          $display("%0t: command with no request waiting, yaw %0d", $time, got.yaw_angle);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          if (got.yaw_angle !== want.yaw_angle)
            report_field("yaw_angle", want.yaw_angle, got.yaw_angle);
          if (got.heading_error !== want.heading_error)
            report_field("heading_error", want.heading_error, got.heading_error);
          if (got.action !== want.action)
            report_field("action", want.action, got.action);
          if (got.drive_speed !== want.drive_speed)
            report_field("drive_speed", want.drive_speed, got.drive_speed);
          if (got.drive_time !== want.drive_time)
            report_field("drive_time", want.drive_time, got.drive_time);
        end
      end
      if (!hold_done && results_seen == HOLD_AT_RESULT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        command_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        command_ch.ready <= 1'b0;
      end else begin
        command_ch.ready <= calm || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sensor_ch.valid && sensor_ch.ready) ||
                 (command_ch.valid && command_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no request or command moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = qyhc_pkg::CFG_GAIN;
    cfg_data = '0;
    sensor_ch.valid = 1'b0;
    sensor_ch.sample_ready = 1'b0;
    sensor_ch.quat_w = '0;
    sensor_ch.quat_x = '0;
    sensor_ch.quat_y = '0;
    sensor_ch.quat_z = '0;
    sensor_ch.target_yaw = '0;
    command_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_request(1, 16384, 0, 0, 0, 0);
    add_request(1, 16384, 0, 0, 0, 48);
    add_request(1, 16384, 0, 0, 0, 49);
    add_request(1, 16384, 0, 0, 0, -49);
    add_request(0, -32768, -32768, -32768, -32768, 2880);
    add_request(0, 32767, 32767, 32767, 32767, -2880);
    add_request(0, 0, 0, 0, 0, -4096);
    add_request(0, 0, 0, 0, 0, 4095);
    add_request(0, 1234, -555, 77, 9000, 20);
    add_request(1, 0, 0, 8192, 8192, 100);
    add_request(1, 0, 0, 0, 16384, 0);
    add_request(1, -1, 0, 0, 16384, 2880);
    add_request(1, 11585, 0, 0, 11585, 0);
    add_request(1, 11585, 0, 0, -11585, 0);
    add_request(1, -32768, -32768, -32768, -32768, 0);
    add_request(1, 32767, 32767, 32767, 32767, 0);
    add_request(1, -32768, 32767, -32768, 32767, 1000);
    add_request(1, 16384, 16384, 16384, 16384, -2880);
    add_request(1, -16384, -16384, 16384, -16384, 2880);
    add_request(1, 0, 16384, 0, 0, 5);
    add_request(1, 12000, -3000, 7000, -9000, -1500);
    drain();

    configure(16'd15, 16'd255, 16'd0, 16'd65535);
    add_random(150);
    drain();

    configure(16'd0, 16'd0, 16'd4095, 16'd0);
    add_random(80);
    drain();

    configure(16'($urandom_range(1, 14)), 16'($urandom_range(1, 254)),
              16'($urandom_range(16, 400)), 16'($urandom_range(1, 65534)));
    calm = 1'b1;
    add_random(150);
    drain();
    calm = 1'b0;

    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    add_random(200);
    drain();

    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
